@@ rtl/stepper_homing_sequencer_unit_defines.svh @@
// Assertion macros shared by the homing sequencer RTL.
`ifndef STEPPER_HOMING_SEQUENCER_UNIT_DEFINES_SVH
`define STEPPER_HOMING_SEQUENCER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property at every clock edge outside reset.
`define SHS_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property at every clock edge, reset included.
`define SHS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHS_ASSERT_RST(label, clk, rst_n, prop, msg)
`define SHS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ rtl/shs_pkg.sv @@
// Types and constants of the stepper homing sequencer.
`timescale 1ns / 1ps
package shs_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RateW   = 16;
  localparam int unsigned WinW    = 16;
  localparam int unsigned DebW    = 4;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW      = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SEARCH_RATE = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_CHECK_RATE  = 2'd3;

  localparam logic [DebW-1:0]  DEBOUNCE_RST    = 4'd2;
  localparam logic [WinW-1:0]  WINDOW_RST      = 16'd4000;
  localparam logic [RateW-1:0] SEARCH_RATE_RST = 16'd1000;
  localparam logic [RateW-1:0] CHECK_RATE_RST  = 16'd400;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_SEARCH     = 4'd1,
    PH_LEAVE      = 4'd2,
    PH_WINDOW     = 4'd3,
    PH_RETURN     = 4'd4,
    PH_ESC_LEAVE  = 4'd5,
    PH_ESC_FIND   = 4'd6,
    PH_ESC_PASS   = 4'd7,
    PH_R_LEAVE    = 4'd8,
    PH_R_WINDOW   = 4'd9,
    PH_BACK       = 4'd10,
    PH_L_LEAVE    = 4'd11,
    PH_L_WINDOW   = 4'd12,
    PH_CENTER     = 4'd13,
    PH_DONE       = 4'd14
  } shs_phase_t;

  typedef struct packed {
    logic cmd;
    logic hall_active;
  } shs_in_t;

  typedef struct packed {
    logic             motor_running;
    logic             direction;
    logic [RateW-1:0] step_rate_hz;
    logic             driver_enabled;
    logic             led_on;
    logic             homing_done;
    logic [3:0]       phase;
  } shs_out_t;

endpackage

@@ rtl/shs_stream_if.sv @@
// Valid/ready item channel used on both sides of the homing sequencer.
`timescale 1ns / 1ps
interface shs_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/stepper_homing_sequencer_unit.sv @@
// Stepper homing sequencer: input stage, phase logic and result register.
// An accepted item is registered in the input stage, then moved into the result register.
// Throughput: one item per cycle; a held result stalls the input only when both stages are full.
// The phase update for an item happens as it moves from the input stage to the result register.
// Reset (synchronous, rst_n low) empties both stages, returns to idle heading right,
// and loads the default debounce, window and rate settings.
`timescale 1ns / 1ps
`include "stepper_homing_sequencer_unit_defines.svh"
module stepper_homing_sequencer_unit
  import shs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  shs_stream_if.sink          in_chan,
  shs_stream_if.source        out_chan,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [RateW-1:0]    cfg_wdata
);

  // configuration
  logic [DebW-1:0]  deb_r;
  logic [WinW-1:0]  ovs_r;
  logic [RateW-1:0] srch_rate_r;
  logic [RateW-1:0] chk_rate_r;

  // input stage
  logic    s1_valid_r;
  shs_in_t s1_data_r;

  // result stage
  logic     out_valid_r;
  shs_out_t out_data_r;
  shs_out_t out_data_nxt;

  // sequencer state
  shs_phase_t      step_r, step_nxt;
  logic            dir_r, dir_nxt;
  logic [DebW-1:0] run_r, run_nxt;
  logic [WinW-1:0] win_r, win_nxt;
  logic            mot_r, mot_nxt;
  logic            srch_r, srch_nxt;
  logic            drv_r, drv_nxt;
  logic            led_r, led_nxt;

  logic            advance;
  logic            fire;
  logic            hall;
  logic            want;
  logic            match;
  logic [DebW-1:0] run_inc;
  logic            settled;
  logic [DebW-1:0] run_settle;
  logic            w_end;
  logic            w_clear;
  logic [DebW-1:0] w_run;
  logic [RateW-1:0] rate_sel;
  logic            in_window;
  logic            in_escape;

  assign advance        = !out_valid_r || out_chan.ready;
  assign fire           = s1_valid_r && advance;
  assign in_chan.ready  = !s1_valid_r || advance;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= DEBOUNCE_RST;
      ovs_r       <= WINDOW_RST;
      srch_rate_r <= SEARCH_RATE_RST;
      chk_rate_r  <= CHECK_RATE_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DEBOUNCE:    deb_r       <= cfg_wdata[DebW-1:0];
        CFG_WINDOW:      ovs_r       <= cfg_wdata[WinW-1:0];
        CFG_SEARCH_RATE: srch_rate_r <= cfg_wdata;
        CFG_CHECK_RATE:  chk_rate_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_data_r <= in_chan.data;
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= PH_IDLE;
      dir_r  <= 1'b1;
      run_r  <= '0;
      win_r  <= '0;
      mot_r  <= 1'b0;
      srch_r <= 1'b1;
      drv_r  <= 1'b0;
      led_r  <= 1'b0;
    end else if (fire) begin
      step_r <= step_nxt;
      dir_r  <= dir_nxt;
      run_r  <= run_nxt;
      win_r  <= win_nxt;
      mot_r  <= mot_nxt;
      srch_r <= srch_nxt;
      drv_r  <= drv_nxt;
      led_r  <= led_nxt;
    end
  end

  // debounce and window sampling terms shared by all phases except idle and done
  always_comb begin
    hall    = s1_data_r.hall_active;
    want    = !(step_r == PH_LEAVE || step_r == PH_R_LEAVE || step_r == PH_L_LEAVE ||
                step_r == PH_ESC_LEAVE || step_r == PH_ESC_PASS);
    match   = (hall == want);
    run_inc = run_r + 4'd1;
    settled = match && (run_inc >= deb_r);
    run_settle = (match && !settled) ? run_inc : '0;
    w_end   = hall && (run_inc >= deb_r);
    w_run   = hall ? run_inc : '0;
    w_clear = !w_end && (win_r >= ovs_r);
  end

  always_comb begin
    step_nxt = step_r;
    dir_nxt  = dir_r;
    run_nxt  = run_r;
    win_nxt  = win_r;
    mot_nxt  = mot_r;
    srch_nxt = srch_r;
    drv_nxt  = drv_r;
    led_nxt  = led_r;

    if (s1_data_r.cmd) begin
      unique case (step_r)
        PH_IDLE, PH_DONE: begin
          drv_nxt  = 1'b1;
          led_nxt  = 1'b0;
          dir_nxt  = 1'b1;
          mot_nxt  = 1'b1;
          run_nxt  = '0;
          win_nxt  = '0;
          srch_nxt = !hall;
          step_nxt = hall ? PH_R_LEAVE : PH_SEARCH;
        end
        default: ;  // busy: drop the start
      endcase
    end else begin
      unique case (step_r)
        PH_SEARCH: begin
          run_nxt = run_settle;
          if (settled) begin
            srch_nxt = 1'b0;
            step_nxt = PH_LEAVE;
          end
        end
        PH_LEAVE, PH_R_LEAVE, PH_L_LEAVE, PH_BACK, PH_ESC_LEAVE, PH_ESC_FIND: begin
          run_nxt = run_settle;
          if (settled) begin
            run_nxt = '0;
            win_nxt = '0;
            unique case (step_r)
              PH_LEAVE:     step_nxt = PH_WINDOW;
              PH_R_LEAVE:   step_nxt = PH_R_WINDOW;
              PH_L_LEAVE:   step_nxt = PH_L_WINDOW;
              PH_BACK:      step_nxt = PH_L_LEAVE;
              PH_ESC_LEAVE: step_nxt = PH_ESC_FIND;
              default:      step_nxt = PH_ESC_PASS;
            endcase
          end
        end
        PH_WINDOW, PH_R_WINDOW, PH_L_WINDOW: begin
          run_nxt = w_run;
          if (w_end) begin
            // second magnet: endstop, reverse and escape
            led_nxt  = 1'b1;
            dir_nxt  = !dir_r;
            srch_nxt = 1'b1;
            mot_nxt  = 1'b1;
            run_nxt  = '0;
            win_nxt  = '0;
            step_nxt = PH_ESC_LEAVE;
          end else if (w_clear) begin
            mot_nxt = 1'b1;
            run_nxt = '0;
            win_nxt = '0;
            unique case (step_r)
              PH_WINDOW: begin
                dir_nxt  = !dir_r;
                srch_nxt = 1'b0;
                step_nxt = PH_RETURN;
              end
              PH_R_WINDOW: begin
                dir_nxt  = 1'b0;
                step_nxt = PH_BACK;
              end
              default: begin
                dir_nxt  = 1'b1;
                step_nxt = PH_CENTER;
              end
            endcase
          end else begin
            win_nxt = win_r + 16'd1;
          end
        end
        PH_RETURN, PH_CENTER: begin
          run_nxt = run_settle;
          if (settled) begin
            mot_nxt  = 1'b0;
            drv_nxt  = 1'b0;
            led_nxt  = 1'b1;
            run_nxt  = '0;
            win_nxt  = '0;
            step_nxt = PH_DONE;
          end
        end
        PH_ESC_PASS: begin
          run_nxt = run_settle;
          if (settled) begin
            led_nxt  = 1'b0;
            srch_nxt = 1'b1;
            mot_nxt  = 1'b1;
            run_nxt  = '0;
            win_nxt  = '0;
            step_nxt = PH_SEARCH;
          end
        end
        default: ;  // idle and done hold
      endcase
    end

    rate_sel = srch_nxt ? srch_rate_r : chk_rate_r;

    out_data_nxt.motor_running  = mot_nxt;
    out_data_nxt.direction      = dir_nxt;
    out_data_nxt.step_rate_hz   = (rate_sel == '0) ? 16'd1 : rate_sel;
    out_data_nxt.driver_enabled = drv_nxt;
    out_data_nxt.led_on         = led_nxt;
    out_data_nxt.homing_done    = (step_nxt == PH_DONE);
    out_data_nxt.phase          = step_nxt;
  end

  assign in_window = step_r == PH_WINDOW || step_r == PH_R_WINDOW || step_r == PH_L_WINDOW;
  assign in_escape = step_r == PH_ESC_LEAVE || step_r == PH_ESC_FIND || step_r == PH_ESC_PASS;

  `SHS_ASSERT_RST(a_done_stopped, clk, rst_n, step_r == PH_DONE |-> !mot_r && !drv_r && led_r,
                  "done with motor or driver on")
  `SHS_ASSERT_RST(a_win_idle_zero, clk, rst_n, !in_window |-> win_r == '0,
                  "window count left over outside a window phase")
  `SHS_ASSERT_RST(a_escape_led, clk, rst_n, in_escape |-> led_r && srch_r && mot_r,
                  "escape without led or search rate")
  `SHS_ASSERT_RST(a_fire_fills_out, clk, rst_n, fire |=> out_valid_r && out_data_r.phase == step_r,
                  "item lost between input stage and result register")
  `SHS_ASSERT_RST(a_result_done_stopped, clk, rst_n,
                  out_valid_r && out_data_r.homing_done |-> !out_data_r.motor_running,
                  "result reports done while running")

endmodule
